// ----- sv/bslps_pkg.sv -----
// Shared types and constants of the button short/long press splitter.
package bslps_pkg;

   // Field widths
   localparam int CODE_W     = 8;
   localparam int LIMIT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Default width of the hold timer
   localparam int TIME_BITS_DEF = 16;

   // Button code that means no data; also the blocking reply
   localparam logic [CODE_W-1:0] NO_DATA = 8'hFF;

   // Register reset values
   localparam logic [CODE_W-1:0]  RELEASE_CODE_RST = 8'd0;
   localparam logic [CODE_W-1:0]  LONG_OFFSET_RST  = 8'd32;
   localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST   = 16'd1000;
   localparam logic [CODE_W-1:0]  SEND_DELAY_RST   = 8'd100;
   localparam logic [CODE_W-1:0]  IGNORE_CODE_RST  = 8'hFF;

   // Input action codes
   localparam logic ACT_EVENT = 1'b0;
   localparam logic ACT_TICK  = 1'b1;

   // Result kinds
   localparam logic KIND_REPLY  = 1'b0;
   localparam logic KIND_QUEUED = 1'b1;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RELEASE_CODE  = 3'd0,
      CSR_LONG_OFFSET   = 3'd1,
      CSR_LONG_LIMIT    = 3'd2,
      CSR_SEND_DELAY    = 3'd3,
      CSR_IGNORE_A      = 3'd4,
      CSR_IGNORE_B      = 3'd5,
      CSR_IGNORE_C      = 3'd6
   } csr_index_type;

   // One result word
   typedef struct packed {
      logic              result_kind;
      logic [CODE_W-1:0] out_code;
      logic [CODE_W-1:0] send_delay;
      logic              last_of_run;
   } result_type;

endpackage

// ----- sv/bslps_if.sv -----
// Valid/ready channel interfaces for button words in and result words out.
interface bslps_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [bslps_pkg::CODE_W-1:0] button_code;

   modport source (output valid, output action, output button_code, input ready);
   modport sink   (input valid, input action, input button_code, output ready);
endinterface

interface bslps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         result_kind;
   logic [bslps_pkg::CODE_W-1:0] out_code;
   logic [bslps_pkg::CODE_W-1:0] send_delay;
   logic                         last_of_run;

   modport source (output valid, output result_kind, output out_code,
                   output send_delay, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input out_code,
                   input send_delay, input last_of_run, output ready);
endinterface

// ----- sv/button_short_long_press_splitter.sv -----
// Top level of the button short/long press splitter.
//
// req_ch carries one word per button event (action 0) or per millisecond
// tick (action 1). Every event yields one immediate reply on rsp_ch with
// last_of_run set; a release that completes a press first yields two queued
// commands (press or long-press code, then the delayed release code), so an
// event makes one or three result words. Ticks make none.
// All decisions are taken in the cycle a word is accepted; its results sit
// in a three-slot result register and appear on rsp_ch in the next cycle,
// one word per cycle while rsp_ch.ready is high. A single-result event
// thus sustains one word per cycle; a completed press takes three slots.
// req_ch.ready is high while the result register is empty or its last word
// is leaving, so a stalled receiver holds off new words after at most one
// buffered run. The user writes configuration over csr_we/csr_index/csr_wdata
// only while idle (not enforced). Indexes past the register map are dropped.
// Reset (synchronous, active high) clears the press latch, the pass-through
// flag, the hold timer and the result register, and loads register defaults.
module button_short_long_press_splitter #(
   parameter int TIME_BITS = bslps_pkg::TIME_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   bslps_req_if.sink                        req_ch,
   bslps_rsp_if.source                      rsp_ch,
   input  logic                             csr_we,
   input  logic [bslps_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bslps_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW    = bslps_pkg::CODE_W;
   localparam int LW    = bslps_pkg::LIMIT_W;
   localparam int CMP_W = (TIME_BITS > LW) ? TIME_BITS : LW;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   // Configuration registers
   logic [CW-1:0] release_code_ff;
   logic [CW-1:0] long_offset_ff;
   logic [LW-1:0] long_limit_ff;
   logic [CW-1:0] send_delay_ff;
   logic [CW-1:0] ignore_a_ff;
   logic [CW-1:0] ignore_b_ff;
   logic [CW-1:0] ignore_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         release_code_ff <= bslps_pkg::RELEASE_CODE_RST;
         long_offset_ff  <= bslps_pkg::LONG_OFFSET_RST;
         long_limit_ff   <= bslps_pkg::LONG_LIMIT_RST;
         send_delay_ff   <= bslps_pkg::SEND_DELAY_RST;
         ignore_a_ff     <= bslps_pkg::IGNORE_CODE_RST;
         ignore_b_ff     <= bslps_pkg::IGNORE_CODE_RST;
         ignore_c_ff     <= bslps_pkg::IGNORE_CODE_RST;
      end else if (csr_we) begin
         unique case (bslps_pkg::csr_index_type'(csr_index))
            bslps_pkg::CSR_RELEASE_CODE: release_code_ff <= csr_wdata[CW-1:0];
            bslps_pkg::CSR_LONG_OFFSET:  long_offset_ff  <= csr_wdata[CW-1:0];
            bslps_pkg::CSR_LONG_LIMIT:   long_limit_ff   <= csr_wdata[LW-1:0];
            bslps_pkg::CSR_SEND_DELAY:   send_delay_ff   <= csr_wdata[CW-1:0];
            bslps_pkg::CSR_IGNORE_A:     ignore_a_ff     <= csr_wdata[CW-1:0];
            bslps_pkg::CSR_IGNORE_B:     ignore_b_ff     <= csr_wdata[CW-1:0];
            bslps_pkg::CSR_IGNORE_C:     ignore_c_ff     <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // Press state and result register
   logic                   press_pending_ff, press_pending_in;
   logic [CW-1:0]          held_code_ff,     held_code_in;
   logic                   passthrough_ff,   passthrough_in;
   logic [TIME_BITS-1:0]   held_time_ff,     held_time_in;

   bslps_pkg::result_type  slot_ff [3];
   bslps_pkg::result_type  slot_in [3];
   logic [1:0]             cnt_ff, cnt_in;
   logic [1:0]             rd_ff,  rd_in;

   logic          req_fire, event_fire, tick_fire, rsp_fire;
   logic [CW-1:0] code;
   logic          is_ignored, is_long;
   logic [CW-1:0] cmd_code;
   logic [CMP_W-1:0] held_ext, limit_ext;
   bslps_pkg::result_type reply_blk, reply_pass;

   // Handshake: take a word when the result register empties this cycle
   assign rsp_ch.valid = (cnt_ff != 2'd0);
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign event_fire   = req_fire && (req_ch.action == bslps_pkg::ACT_EVENT);
   assign tick_fire    = req_fire && (req_ch.action == bslps_pkg::ACT_TICK);
   assign code         = req_ch.button_code;

   // Decode helpers
   assign is_ignored = (code == ignore_a_ff) || (code == ignore_b_ff) ||
                       (code == ignore_c_ff);
   assign held_ext   = CMP_W'(held_time_ff);
   assign limit_ext  = CMP_W'(long_limit_ff);
   assign is_long    = (held_ext > limit_ext);
   assign cmd_code   = is_long ? CW'(held_code_ff + long_offset_ff) : held_code_ff;

   assign reply_blk  = '{result_kind: bslps_pkg::KIND_REPLY, out_code: bslps_pkg::NO_DATA,
                         send_delay: '0, last_of_run: 1'b1};
   assign reply_pass = '{result_kind: bslps_pkg::KIND_REPLY, out_code: code,
                         send_delay: '0, last_of_run: 1'b1};

   // Per-word decision and result register update
   always_comb begin
      press_pending_in = press_pending_ff;
      held_code_in     = held_code_ff;
      passthrough_in   = passthrough_ff;
      held_time_in     = held_time_ff;
      slot_in          = slot_ff;
      cnt_in           = cnt_ff;
      rd_in            = rd_ff;

      // drain one word
      if (rsp_fire) begin
         cnt_in = cnt_ff - 2'd1;
         rd_in  = rd_ff + 2'd1;
      end

      // tick: saturating hold timer
      if (tick_fire && (held_time_ff != TIME_MAX)) begin
         held_time_in = held_time_ff + TIME_BITS'(1);
      end

      if (event_fire) begin
         rd_in      = 2'd0;
         cnt_in     = 2'd1;
         slot_in[0] = reply_blk;
         if (code == bslps_pkg::NO_DATA) begin
            slot_in[0] = reply_blk;
         end else if ((code == release_code_ff) && passthrough_ff) begin
            passthrough_in = 1'b0;
            slot_in[0]     = reply_pass;
         end else if (is_ignored) begin
            passthrough_in = 1'b1;
            slot_in[0]     = reply_pass;
         end else if (!press_pending_ff) begin
            // latch a new press
            if (code > release_code_ff) begin
               held_time_in     = '0;
               held_code_in     = code;
               press_pending_in = 1'b1;
            end
         end else if (code == release_code_ff) begin
            // release completes the press: two commands then the reply
            press_pending_in = 1'b0;
            held_code_in     = '0;
            cnt_in           = 2'd3;
            slot_in[0] = '{result_kind: bslps_pkg::KIND_QUEUED, out_code: cmd_code,
                           send_delay: '0, last_of_run: 1'b0};
            slot_in[1] = '{result_kind: bslps_pkg::KIND_QUEUED, out_code: release_code_ff,
                           send_delay: send_delay_ff, last_of_run: 1'b0};
            slot_in[2] = reply_blk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_pending_ff <= 1'b0;
         held_code_ff     <= '0;
         passthrough_ff   <= 1'b0;
         held_time_ff     <= '0;
         cnt_ff           <= 2'd0;
         rd_ff            <= 2'd0;
      end else begin
         press_pending_ff <= press_pending_in;
         held_code_ff     <= held_code_in;
         passthrough_ff   <= passthrough_in;
         held_time_ff     <= held_time_in;
         cnt_ff           <= cnt_in;
         rd_ff            <= rd_in;
      end
   end

   // Result slots hold payload only
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   // Output word
   assign rsp_ch.result_kind = slot_ff[rd_ff].result_kind;
   assign rsp_ch.out_code    = slot_ff[rd_ff].out_code;
   assign rsp_ch.send_delay  = slot_ff[rd_ff].send_delay;
   assign rsp_ch.last_of_run = slot_ff[rd_ff].last_of_run;

   // Every accepted event shows a result word in the next cycle
   a_event_gives_result: assert property (@(posedge clock) disable iff (reset)
      event_fire |=> rsp_ch.valid)
      else $error("accepted event produced no result");

   // Once the last word of a run leaves with nothing new taken, output goes idle
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last_of_run && !event_fire) |=> !rsp_ch.valid)
      else $error("result words after end of run");

   // A queued command is never the last word of a run
   a_queued_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.result_kind == bslps_pkg::KIND_QUEUED))
         |-> !rsp_ch.last_of_run)
      else $error("queued command marked last");

   // A press is only cleared by an accepted release event
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      $fell(press_pending_ff) |-> $past(event_fire && (code == release_code_ff)))
      else $error("press cleared without release");

   // A completed press starts a three-word run at slot zero
   a_run_of_three: assert property (@(posedge clock) disable iff (reset)
      $fell(press_pending_ff) |-> ((cnt_ff == 2'd3) && (rd_ff == 2'd0)))
      else $error("release did not queue three words");

endmodule

// ----- tb/button_short_long_press_splitter_tb.sv -----
// Testbench of the button short/long press splitter: directed and random words against a predictor.
`timescale 1ns / 1ps

module button_short_long_press_splitter_tb;

   localparam int TIME_W = bslps_pkg::TIME_BITS_DEF;
   localparam int CODE_W = bslps_pkg::CODE_W;
   localparam int LIMIT_W = bslps_pkg::LIMIT_W;
   localparam int CSR_DATA_W = bslps_pkg::CSR_DATA_W;

   logic clock;
   logic reset;
   logic csr_we;
   logic [bslps_pkg::CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bslps_req_if req_ch ();
   bslps_rsp_if rsp_ch ();

   button_short_long_press_splitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies
   logic [CODE_W-1:0]  cfg_release;
   logic [CODE_W-1:0]  cfg_offset;
   logic [LIMIT_W-1:0] cfg_limit;
   logic [CODE_W-1:0]  cfg_delay;
   logic [CODE_W-1:0]  cfg_ignore_a;
   logic [CODE_W-1:0]  cfg_ignore_b;
   logic [CODE_W-1:0]  cfg_ignore_c;

   // Splitter state copies
   logic              press_latched;
   logic [CODE_W-1:0] latched_code;
   logic              pass_flag;
   logic [TIME_W-1:0] hold_ms;

   bslps_pkg::result_type owed_results[$];
   int  mismatch_count = 0;
   int  words_sent = 0;
   bit  tx_gaps_on = 1'b1;
   bit  rx_stalls_on = 1'b1;
   int  stall_left = 0;

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Gap length: mostly short, now and then long
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void owe(logic kind, logic [CODE_W-1:0] code,
                               logic [CODE_W-1:0] dly, logic last);
      bslps_pkg::result_type w;
      w.result_kind = kind;
      w.out_code    = code;
      w.send_delay  = dly;
      w.last_of_run = last;
      owed_results.push_back(w);
   endfunction

   // Predict the results of one accepted word and advance the state copies
   function automatic void split_button_word(logic act, logic [CODE_W-1:0] code);
      logic [CODE_W-1:0] cmd;
      if (act == bslps_pkg::ACT_TICK) begin
         if (hold_ms != '1) hold_ms++;
         return;
      end
      if (code == bslps_pkg::NO_DATA) begin
         owe(bslps_pkg::KIND_REPLY, bslps_pkg::NO_DATA, '0, 1'b1);
         return;
      end
      // a release while the pass flag is set (after an ignored button) clears the flag
      if (code == cfg_release && pass_flag) begin
         pass_flag = 1'b0;
         owe(bslps_pkg::KIND_REPLY, code, '0, 1'b1);
         return;
      end
      if (code == cfg_ignore_a || code == cfg_ignore_b || code == cfg_ignore_c) begin
         pass_flag = 1'b1;
         owe(bslps_pkg::KIND_REPLY, code, '0, 1'b1);
         return;
      end
      if (!press_latched) begin
         if (code > cfg_release) begin
            hold_ms       = '0;
            latched_code  = code;
            press_latched = 1'b1;
         end
      end else if (code == cfg_release) begin
         press_latched = 1'b0;
         if (hold_ms > cfg_limit) cmd = latched_code + cfg_offset;
         else cmd = latched_code;
         owe(bslps_pkg::KIND_QUEUED, cmd, '0, 1'b0);
         owe(bslps_pkg::KIND_QUEUED, cfg_release, cfg_delay, 1'b0);
         latched_code = '0;
      end
      owe(bslps_pkg::KIND_REPLY, bslps_pkg::NO_DATA, '0, 1'b1);
   endfunction

   // Send one word, then maybe leave a gap
   task automatic send_word(logic act, logic [CODE_W-1:0] code);
      @(negedge clock);
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.button_code <= code;
      do @(posedge clock); while (!req_ch.ready);
      split_button_word(act, code);
      words_sent++;
      if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (pick_gap() - 1) @(negedge clock);
      end
   endtask

   task automatic press_event(logic [CODE_W-1:0] code);
      send_word(bslps_pkg::ACT_EVENT, code);
   endtask

   task automatic ticks(int n);
      repeat (n) send_word(bslps_pkg::ACT_TICK, 8'($urandom_range(0, 255)));
   endtask

   // Stop sending and wait until every owed result has come out
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(bslps_pkg::csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         bslps_pkg::CSR_RELEASE_CODE: cfg_release  = data[CODE_W-1:0];
         bslps_pkg::CSR_LONG_OFFSET:  cfg_offset   = data[CODE_W-1:0];
         bslps_pkg::CSR_LONG_LIMIT:   cfg_limit    = data[LIMIT_W-1:0];
         bslps_pkg::CSR_SEND_DELAY:   cfg_delay    = data[CODE_W-1:0];
         bslps_pkg::CSR_IGNORE_A:     cfg_ignore_a = data[CODE_W-1:0];
         bslps_pkg::CSR_IGNORE_B:     cfg_ignore_b = data[CODE_W-1:0];
         bslps_pkg::CSR_IGNORE_C:     cfg_ignore_c = data[CODE_W-1:0];
         default: ;
      endcase
   endtask

   // Idle the block, then load all seven registers
   task automatic configure(logic [7:0] rel, logic [7:0] off, logic [15:0] lim,
                            logic [7:0] dly, logic [7:0] ia, logic [7:0] ib,
                            logic [7:0] ic);
      drain();
      write_reg(bslps_pkg::CSR_RELEASE_CODE, 16'(rel));
      write_reg(bslps_pkg::CSR_LONG_OFFSET, 16'(off));
      write_reg(bslps_pkg::CSR_LONG_LIMIT, lim);
      write_reg(bslps_pkg::CSR_SEND_DELAY, 16'(dly));
      write_reg(bslps_pkg::CSR_IGNORE_A, 16'(ia));
      write_reg(bslps_pkg::CSR_IGNORE_B, 16'(ib));
      write_reg(bslps_pkg::CSR_IGNORE_C, 16'(ic));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Random press code above release, off the ignore list unless eight draws fail; 254 at the top
   function automatic logic [CODE_W-1:0] pick_press();
      logic [CODE_W-1:0] c;
      if (cfg_release >= 8'd254) return 8'd254;
      for (int i = 0; i < 8; i++) begin
         c = 8'($urandom_range(int'(cfg_release) + 1, 254));
         if (c != cfg_ignore_a && c != cfg_ignore_b && c != cfg_ignore_c) return c;
      end
      return c;
   endfunction

   function automatic logic [CODE_W-1:0] pick_ignore();
      case ($urandom_range(0, 3))
         0: return bslps_pkg::NO_DATA;
         1: return cfg_release;
         default: return 8'($urandom_range(0, 254));
      endcase
   endfunction

   // Reset defaults: short press, no data, idle release, repeated press
   task automatic test_reset_defaults();
      press_event(8'h05);
      ticks(2);
      press_event(8'h00);
      press_event(bslps_pkg::NO_DATA);
      press_event(8'h00);
      press_event(8'h80);
      press_event(8'h90);
      press_event(8'h00);
   endtask

   // Field extremes: max code with max offset, zero limit, top release code
   task automatic test_field_extremes();
      configure(8'd0, 8'd255, 16'd0, 8'd255, 8'hFF, 8'hFF, 8'hFF);
      press_event(8'hFE);
      ticks(1);
      press_event(8'h00);
      press_event(8'h01);
      press_event(8'h00);
      configure(8'd254, 8'd0, 16'hFFFF, 8'd0, 8'hFF, 8'hFF, 8'hFF);
      press_event(8'd254);
      press_event(8'd0);
   endtask

   // Ignore list and the release that follows an ignored button
   task automatic test_pass_through();
      configure(8'h10, 8'd32, 16'd2, 8'd7, 8'h40, 8'hFF, 8'h00);
      press_event(8'h40);
      press_event(8'h10);
      press_event(8'h50);
      ticks(3);
      press_event(8'h40);
      press_event(8'h10);
      press_event(8'h10);
      press_event(8'h00);
   endtask

   // Long press only once the hold time is above the limit, not equal to it
   task automatic test_limit_boundary();
      configure(8'd0, 8'd1, 16'd3, 8'd1, 8'hFF, 8'hFF, 8'hFF);
      press_event(8'h22);
      ticks(3);
      press_event(8'h00);
      press_event(8'h22);
      ticks(4);
      press_event(8'h00);
   endtask

   // Random traffic of one phase: mostly press/hold/release runs
   task automatic random_phase(int n_words);
      int start;
      int hold;
      logic [CODE_W-1:0] code;
      start = words_sent;
      while (words_sent - start < n_words) begin
         case ($urandom_range(0, 9)) inside
            [0:5]: begin
               code = pick_press();
               press_event(code);
               hold = (cfg_limit <= 40) ? $urandom_range(0, int'(cfg_limit) + 3)
                                        : $urandom_range(0, 8);
               ticks(hold);
               if ($urandom_range(0, 4) == 0) press_event(8'($urandom_range(0, 255)));
               press_event(cfg_release);
            end
            6: press_event(8'($urandom_range(0, 255)));
            7: begin
               case ($urandom_range(0, 2))
                  0: press_event(cfg_ignore_a);
                  1: press_event(cfg_ignore_b);
                  default: press_event(cfg_ignore_c);
               endcase
               if ($urandom_range(0, 1)) press_event(cfg_release);
            end
            8: begin
               press_event(bslps_pkg::NO_DATA);
               ticks($urandom_range(1, 3));
            end
            default: press_event(cfg_release);
         endcase
      end
   endtask

   task automatic test_random_traffic();
      logic [7:0] rel;
      configure(8'd0, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 20)),
                8'($urandom_range(0, 255)), pick_ignore(), pick_ignore(), pick_ignore());
      random_phase(50);
      // sender holds off until all results are out
      drain();
      random_phase(20);
      rel = 8'($urandom_range(0, 120));
      configure(rel, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 30)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rel,
                bslps_pkg::NO_DATA);
      random_phase(60);
      configure(8'($urandom_range(0, 200)), 8'd0, 16'd0, 8'd0,
                pick_ignore(), pick_ignore(), pick_ignore());
      rx_stalls_on = 1'b0;
      tx_gaps_on   = 1'b0;
      random_phase(40);
      rx_stalls_on = 1'b1;
      tx_gaps_on   = 1'b1;
      configure(8'($urandom_range(0, 40)), 8'd255, 16'($urandom_range(0, 12)), 8'd255,
                pick_ignore(), pick_ignore(), pick_ignore());
      random_phase(60);
      configure(8'($urandom_range(0, 60)), 8'($urandom_range(0, 255)), 16'hFFFF,
                8'($urandom_range(0, 255)), pick_ignore(), pick_ignore(), pick_ignore());
      random_phase(40);
   endtask

   // Receiver: random stalls on rsp_ch
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left = pick_gap() - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each result word with the oldest owed one
   always @(posedge clock) begin
      bslps_pkg::result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (owed_results.size() == 0) begin
            $error("unexpected result word: kind %0d code %0d delay %0d last %0d",
                   rsp_ch.result_kind, rsp_ch.out_code, rsp_ch.send_delay,
                   rsp_ch.last_of_run);
            mismatch_count++;
         end else begin
            want = owed_results.pop_front();
            if (rsp_ch.result_kind !== want.result_kind) begin
               $error("result_kind: expected %0d, got %0d", want.result_kind,
                      rsp_ch.result_kind);
               mismatch_count++;
            end
            if (rsp_ch.out_code !== want.out_code) begin
               $error("out_code: expected %0d, got %0d", want.out_code, rsp_ch.out_code);
               mismatch_count++;
            end
            if (rsp_ch.send_delay !== want.send_delay) begin
               $error("send_delay: expected %0d, got %0d", want.send_delay,
                      rsp_ch.send_delay);
               mismatch_count++;
            end
            if (rsp_ch.last_of_run !== want.last_of_run) begin
               $error("last_of_run: expected %0d, got %0d", want.last_of_run,
                      rsp_ch.last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // Run limit
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.action      = bslps_pkg::ACT_EVENT;
      req_ch.button_code = '0;
      rsp_ch.ready       = 1'b0;
      cfg_release   = bslps_pkg::RELEASE_CODE_RST;
      cfg_offset    = bslps_pkg::LONG_OFFSET_RST;
      cfg_limit     = bslps_pkg::LONG_LIMIT_RST;
      cfg_delay     = bslps_pkg::SEND_DELAY_RST;
      cfg_ignore_a  = bslps_pkg::IGNORE_CODE_RST;
      cfg_ignore_b  = bslps_pkg::IGNORE_CODE_RST;
      cfg_ignore_c  = bslps_pkg::IGNORE_CODE_RST;
      press_latched = 1'b0;
      latched_code  = '0;
      pass_flag     = 1'b0;
      hold_ms       = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_pass_through();
      test_limit_boundary();
      test_random_traffic();

      drain();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- files.f -----
sv/bslps_pkg.sv
sv/bslps_if.sv
sv/button_short_long_press_splitter.sv
tb/button_short_long_press_splitter_tb.sv
